@@ src/ftws_pkg.sv @@
// Shared constants and types for the frame time window statistics core.
`default_nettype none

package ftws_pkg;

   localparam int WINDOW_DEFAULT = 60;
   localparam int MS_W           = 16;
   localparam int SAMPLE_W       = 10;
   localparam int RATE_W         = 10;
   localparam int DIFF_W         = 11;
   localparam int MAX_MS         = 1000;
   localparam int DIV_STEPS      = 5;
   localparam int STEP_W         = 3;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(MAX_MS);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(1);

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_RECORD = 2'd1,
      CMD_RAW    = 2'd2,
      CMD_AVG    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAW_RD,
      ST_WALK,
      ST_DIV_RATE,
      ST_DIV_MIN,
      ST_DIV_MAX,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

@@ src/frame_time_window_stats_core.sv @@
// Sliding window frame rate statistics: history memory, walker and shared divider.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-------------------------------------
//  req      | in        | req_valid/stall  | req_command, req_frame_millis
//  rsp      | out       | rsp_valid/stall  | rsp_rate, rsp_best_excess,
//           |           |                  | rsp_worst_deficit
//
// Clear and record are taken in ST_IDLE and do not stall. A raw query goes ST_RAW_RD,
// ST_DIV_RATE, ST_OUT; an averaged query walks the history memory one entry per cycle, then
// runs ST_DIV_RATE, ST_DIV_MIN, ST_DIV_MAX on the shared two-bit-per-cycle divider, then ST_OUT.
// Reset is synchronous; per-entry valid bits make the history read as all ones at once.
// req_stall stays high while a query is in flight; a finished result waits in the rsp
// register, and records and clears are still taken while it is held.
`default_nettype none

module frame_time_window_stats_core
   import ftws_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_command,
   input  wire logic signed [MS_W-1:0]   req_frame_millis,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [RATE_W-1:0]             rsp_rate,
   output logic signed [DIFF_W-1:0]      rsp_best_excess,
   output logic signed [DIFF_W-1:0]      rsp_worst_deficit
);

   localparam int AW    = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = $clog2(WINDOW * MAX_MS + 1);
   localparam int DEN_W = SUM_W + RATE_W;
   localparam logic [SUM_W-1:0] WIN_TOTAL = SUM_W'(WINDOW * MAX_MS);
   localparam logic [SUM_W-1:0] ONE_SEC   = SUM_W'(MAX_MS);
   localparam logic [AW-1:0]    LAST_POS  = AW'(WINDOW - 1);

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] mem [WINDOW];
   logic [WINDOW-1:0]   valid_ff, valid_in;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rd_vld_ff;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       write_pos_ff, write_pos_in;
   logic                mem_we;
   logic [SAMPLE_W-1:0] sat_sample;
   logic [SAMPLE_W-1:0] sample;

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] min_ff, min_in, max_ff, max_in;
   logic                avg_ff, avg_in;

   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [RATE_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [RATE_W-1:0]   rate_ff, rate_in, inv_min_ff, inv_min_in, inv_max_ff, inv_max_in;

   logic [DEN_W:0]      div_rem_ext, div_t1, div_t0, div_r1;
   logic                div_b1, div_b0;
   logic [RATE_W-1:0]   div_q;
   logic [SUM_W-1:0]    div_rem;
   logic                div_last;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]   rsp_rate_ff, rsp_rate_in;
   logic [DIFF_W-1:0]   rsp_best_ff, rsp_best_in, rsp_worst_ff, rsp_worst_in;
   logic                rsp_free;
   logic                req_take;
   cmd_type             cmd;

   assign cmd       = cmd_type'(req_command);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rate          = rsp_rate_ff;
   assign rsp_best_excess   = rsp_best_ff;
   assign rsp_worst_deficit = rsp_worst_ff;

   always_comb begin
      if (req_frame_millis[MS_W-1] || req_frame_millis == '0) begin
         sat_sample = SAMPLE_MIN;
      end else if (req_frame_millis > MS_W'(signed'(MAX_MS))) begin
         sat_sample = SAMPLE_MAX;
      end else begin
         sat_sample = req_frame_millis[SAMPLE_W-1:0];
      end
   end

   assign sample = rd_vld_ff ? rd_data_ff : SAMPLE_MIN;

   // two quotient bits per step, divisor pre-shifted and walked down
   always_comb begin
      div_rem_ext = (DEN_W+1)'(rem_ff);
      div_t1      = {den_ff, 1'b0};
      div_t0      = {1'b0, den_ff};
      div_b1      = (div_rem_ext >= div_t1);
      div_r1      = div_b1 ? div_rem_ext - div_t1 : div_rem_ext;
      div_b0      = (div_r1 >= div_t0);
      div_rem     = div_b0 ? SUM_W'(div_r1 - div_t0) : SUM_W'(div_r1);
      div_q       = {quo_ff[RATE_W-3:0], div_b1, div_b0};
      div_last    = (step_ff == STEP_W'(DIV_STEPS - 1));
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      write_pos_in = write_pos_ff;
      mem_we       = 1'b0;
      rd_addr      = '0;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      avg_in       = avg_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rate_in      = rate_ff;
      inv_min_in   = inv_min_ff;
      inv_max_in   = inv_max_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rate_in  = rsp_rate_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_worst_in = rsp_worst_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (write_pos_ff == '0) ? LAST_POS : write_pos_ff - AW'(1);
            if (req_take) begin
               unique case (cmd)
                  CMD_CLEAR: begin
                     valid_in     = '0;
                     write_pos_in = '0;
                  end
                  CMD_RECORD: begin
                     mem_we                 = 1'b1;
                     valid_in[write_pos_ff] = 1'b1;
                     write_pos_in = (write_pos_ff == LAST_POS) ? '0 : write_pos_ff + AW'(1);
                  end
                  CMD_RAW: begin
                     avg_in   = 1'b0;
                     state_in = ST_RAW_RD;
                  end
                  CMD_AVG: begin
                     rd_addr  = '0;
                     avg_in   = 1'b1;
                     cnt_in   = CNT_W'(1);
                     sum_in   = '0;
                     min_in   = SAMPLE_MAX;
                     max_in   = SAMPLE_MIN;
                     state_in = ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_RAW_RD: begin
            rem_in   = ONE_SEC;
            den_in   = DEN_W'(sample) << (RATE_W - 2);
            quo_in   = '0;
            step_in  = '0;
            state_in = ST_DIV_RATE;
         end
         ST_WALK: begin
            sum_in  = sum_ff + SUM_W'(sample);
            min_in  = (sample < min_ff) ? sample : min_ff;
            max_in  = (sample > max_ff) ? sample : max_ff;
            if (cnt_ff == CNT_W'(WINDOW)) begin
               rem_in   = WIN_TOTAL;
               den_in   = DEN_W'(sum_in) << (RATE_W - 2);
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIV_RATE;
            end else begin
               rd_addr = cnt_ff[AW-1:0];
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         ST_DIV_RATE, ST_DIV_MIN, ST_DIV_MAX: begin
            rem_in  = div_rem;
            den_in  = den_ff >> 2;
            quo_in  = div_q;
            step_in = step_ff + STEP_W'(1);
            if (div_last) begin
               rem_in  = ONE_SEC;
               quo_in  = '0;
               step_in = '0;
               unique case (state_ff)
                  ST_DIV_RATE: begin
                     rate_in  = div_q;
                     den_in   = DEN_W'(min_ff) << (RATE_W - 2);
                     state_in = avg_ff ? ST_DIV_MIN : ST_OUT;
                  end
                  ST_DIV_MIN: begin
                     inv_min_in = div_q;
                     den_in     = DEN_W'(max_ff) << (RATE_W - 2);
                     state_in   = ST_DIV_MAX;
                  end
                  default: begin
                     inv_max_in = div_q;
                     state_in   = ST_OUT;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = rate_ff;
               if (avg_ff) begin
                  rsp_best_in  = DIFF_W'(inv_min_ff) - DIFF_W'(rate_ff);
                  rsp_worst_in = DIFF_W'(rate_ff) - DIFF_W'(inv_max_ff);
               end else begin
                  rsp_best_in  = '0;
                  rsp_worst_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[write_pos_ff] <= sat_sample;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         write_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         write_pos_ff <= write_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      sum_ff       <= sum_in;
      min_ff       <= min_in;
      max_ff       <= max_in;
      avg_ff       <= avg_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      rate_ff      <= rate_in;
      inv_min_ff   <= inv_min_in;
      inv_max_ff   <= inv_max_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_best_ff  <= rsp_best_in;
      rsp_worst_ff <= rsp_worst_in;
   end

endmodule

`default_nettype wire
